// ----- rtl/core/positional_voice_mixer_assert.svh -----
// Assertion macros for the positional voice mixer
`ifndef POSITIONAL_VOICE_MIXER_ASSERT_SVH
`define POSITIONAL_VOICE_MIXER_ASSERT_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define PVM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional_voice_mixer: assertion failed");
// antecedent implies consequent in the next cycle
`define PVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional_voice_mixer: assertion failed");
`else
`define PVM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PVM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/pvm_pkg.sv -----
// Types and constants of the positional voice mixer
`timescale 1ns / 1ps

package pvm_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_VOLUME = 1'd1;

   localparam logic [15:0] RESET_MAX_DISTANCE  = 16'd1500;
   localparam logic [6:0]  RESET_MASTER_VOLUME = 7'd100;

   // accumulator width, wraps modulo 2^SUM_W
   localparam int SUM_W = 40;

   // final scaling divisor
   localparam int FINAL_DIVISOR = 101;

   // ceil(2^38 / 101): exact quotient for dividends below 2^31
   localparam logic [31:0] FINAL_RECIP = 32'hA237_C32C;

   // iterations of the shared compare-subtract unit
   localparam int SQRT_STEPS = 24;
   localparam int FRAC_STEPS = 17;
   localparam int CNT_W      = 5;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   // unity in Q1.16
   localparam logic [16:0] Q16_ONE = 17'h10000;

   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [7:0]         channel_volume;
      logic               positional;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic               last_voice;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
   } rsp_data_type;

endpackage

// ----- rtl/core/positional_voice_mixer.sv -----
// Positional voice mixer: gain sequencer, shared arithmetic and frame output
`timescale 1ns / 1ps

// Mixes voices into one stereo frame, one voice per accepted beat. A plain voice goes straight
// to the sample-times-gain steps. A positional voice runs its distance, falloff, pan and two
// pan-gain square roots through one shared compare-subtract unit that retires one result bit
// per cycle; a voice out of range is silenced right after the distance root. A voice marked
// last adds scaling of both sums, division of each by 101 through a reciprocal product taken
// in two passes of the shared multiplier, a floor shift by 8 and saturation, plus any wait
// for the result register to empty. The result register lets the next voice be accepted while
// a finished frame still waits to be taken. Configuration writes take effect at once.
module positional_voice_mixer
   import pvm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_data_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "positional_voice_mixer_assert.svh"

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_DLD, S_DIST, S_CHK, S_FALL, S_AMP, S_PLD, S_PAN,
      S_LLD, S_SQL, S_GL, S_SQR, S_GR, S_GRC, S_MULL, S_MULR, S_ACCR,
      S_FIN, S_FLD, S_FLO, S_FHI, S_FDIV, S_FSAT
   } state_type;

   state_type              state_ff;
   req_data_type           item_ff;
   logic [15:0]            md_ff;
   logic [6:0]             mv_ff;
   logic signed [SUM_W-1:0] left_sum_ff;
   logic signed [SUM_W-1:0] right_sum_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [25:0]            rem_ff;
   logic [47:0]            shf_ff;
   logic [23:0]            quo_ff;
   logic                   sticky_ff;
   logic signed [58:0]     prod_ff;
   logic [31:0]            d2_ff;
   logic [24:0]            amp_ff;
   logic                   pan_clamp_ff;
   logic [16:0]            rpan_ff;
   logic [7:0]             lgain_ff;
   logic [7:0]             rgain_ff;
   logic                   chan_ff;
   logic                   neg_ff;
   logic signed [15:0]     lout_ff;
   logic                   rsp_valid_ff;
   rsp_data_type           rsp_data_ff;

   logic signed [40:0]     mul_a;
   logic signed [17:0]     mul_b;
   logic signed [58:0]     mul_p;
   logic [27:0]            sub_a;
   logic [27:0]            sub_b;
   logic [28:0]            sub_d;
   logic                   sub_ge;
   logic [27:0]            sub_r;
   logic signed [17:0]     pan_num;
   logic [46:0]            fin_abs;
   logic [47:0]            fdiv_sum;
   logic [24:0]            neg_round;
   logic [16:0]            neg_mag;
   logic [16:0]            neg_val;
   logic signed [15:0]     sat_val;
   logic [16:0]            lpan;
   logic                   rsp_slot_free;
   logic                   frame_done;

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;
   assign frame_done    = (state_ff == S_FSAT) && chan_ff && rsp_slot_free;

   // shared multiplier: operand select by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQX: begin
            mul_a = 41'(item_ff.offset_x);
            mul_b = 18'(item_ff.offset_x);
         end
         S_SQY: begin
            mul_a = 41'(item_ff.offset_y);
            mul_b = 18'(item_ff.offset_y);
         end
         S_AMP: begin
            mul_a = 41'(quo_ff[16:0]);
            mul_b = 18'(item_ff.channel_volume);
         end
         S_GL, S_GR: begin
            mul_a = 41'(amp_ff);
            mul_b = 18'(quo_ff[16:0]);
         end
         S_MULL: begin
            mul_a = 41'(item_ff.left_sample);
            mul_b = 18'(lgain_ff);
         end
         S_MULR: begin
            mul_a = 41'(item_ff.right_sample);
            mul_b = 18'(rgain_ff);
         end
         S_FIN: begin
            mul_a = chan_ff ? 41'(right_sum_ff) : 41'(left_sum_ff);
            mul_b = 18'(mv_ff);
         end
         S_FLO: begin
            mul_a = 41'(d2_ff);
            mul_b = 18'(FINAL_RECIP[15:0]);
         end
         S_FHI: begin
            mul_a = 41'(d2_ff);
            mul_b = 18'(FINAL_RECIP[31:16]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // pan numerator: max distance minus x offset
   assign pan_num = $signed({2'b00, md_ff}) - 18'(item_ff.offset_x);

   // shared compare-subtract unit: operand select by step
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      unique case (state_ff)
         S_DIST, S_SQL, S_SQR: begin
            sub_a = {rem_ff, shf_ff[47:46]};
            sub_b = {2'b00, quo_ff, 2'b01};
         end
         S_CHK: begin
            sub_a = {4'b0, md_ff, 8'b0};
            sub_b = {4'b0, quo_ff};
         end
         S_FALL: begin
            sub_a = {2'b00, rem_ff};
            sub_b = {4'b0, md_ff, 8'b0};
         end
         S_PLD: begin
            sub_a = {11'b0, pan_num[16:0]};
            sub_b = {11'b0, md_ff, 1'b0};
         end
         S_PAN: begin
            sub_a = {2'b00, rem_ff};
            sub_b = {11'b0, md_ff, 1'b0};
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge = !sub_d[28];
   assign sub_r  = sub_ge ? sub_d[27:0] : sub_a;

   // magnitude of the scaled sum for the final division
   assign fin_abs = prod_ff[58] ? (~prod_ff[46:0] + 47'd1) : prod_ff[46:0];

   // join the high and low reciprocal products, quotient starts at bit 22
   assign fdiv_sum = shf_ff + {17'b0, prod_ff[46:16]};

   // left pan, clamped to unity
   assign lpan = pan_clamp_ff ? Q16_ONE : quo_ff[16:0];

   // shift right by 8 rounding down, then saturate
   assign neg_round = {1'b0, quo_ff} + 25'd255;
   assign neg_mag   = neg_round[24:8];
   assign neg_val   = 17'd0 - neg_mag;

   always_comb begin
      if (neg_ff) begin
         if (sticky_ff || (neg_mag > 17'd32768)) begin
            sat_val = SAMPLE_MIN;
         end else begin
            sat_val = neg_val[15:0];
         end
      end else begin
         if (sticky_ff || quo_ff[23]) begin
            sat_val = SAMPLE_MAX;
         end else begin
            sat_val = {1'b0, quo_ff[22:8]};
         end
      end
   end

   // sequencer, state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         left_sum_ff  <= '0;
         right_sum_ff <= '0;
         md_ff        <= RESET_MAX_DISTANCE;
         mv_ff        <= RESET_MASTER_VOLUME;
         chan_ff      <= 1'b0;
      end else begin
         // take configuration writes
         if (csr_we) begin
            unique case (csr_idx)
               CSR_MAX_DISTANCE:  md_ff <= csr_wdata[15:0];
               CSR_MASTER_VOLUME: mv_ff <= csr_wdata[6:0];
            endcase
         end

         // raise the result on a finished frame, drop it once taken
         if (frame_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  lgain_ff <= req_data.channel_volume;
                  rgain_ff <= req_data.channel_volume;
                  state_ff <= req_data.positional ? S_SQX : S_MULL;
               end
            end

            // squared distance
            S_SQX: begin
               prod_ff  <= mul_p;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               prod_ff  <= mul_p;
               d2_ff    <= prod_ff[31:0];
               state_ff <= S_DLD;
            end
            S_DLD: begin
               shf_ff   <= {32'(d2_ff + prod_ff[31:0]), 16'b0};
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= CNT_W'(SQRT_STEPS - 1);
               state_ff <= S_DIST;
            end

            // square root, two radicand bits a step
            S_DIST, S_SQL, S_SQR: begin
               rem_ff <= sub_r[25:0];
               quo_ff <= {quo_ff[22:0], sub_ge};
               shf_ff <= {shf_ff[45:0], 2'b00};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  priority if (state_ff == S_DIST) begin
                     state_ff <= S_CHK;
                  end else if (state_ff == S_SQL) begin
                     state_ff <= S_GL;
                  end else begin
                     state_ff <= S_GR;
                  end
               end
            end

            // range check, silence at or beyond max distance
            S_CHK: begin
               if (!sub_ge || (sub_d[27:0] == '0)) begin
                  lgain_ff <= '0;
                  rgain_ff <= '0;
                  state_ff <= S_MULL;
               end else begin
                  rem_ff    <= sub_d[25:0];
                  quo_ff    <= '0;
                  sticky_ff <= 1'b0;
                  shf_ff    <= '0;
                  cnt_ff    <= CNT_W'(FRAC_STEPS - 1);
                  state_ff  <= S_FALL;
               end
            end

            // restoring division, one quotient bit a step
            S_FALL, S_PAN: begin
               rem_ff    <= {sub_r[24:0], shf_ff[47]};
               quo_ff    <= {quo_ff[22:0], sub_ge};
               sticky_ff <= sticky_ff | quo_ff[23];
               shf_ff    <= {shf_ff[46:0], 1'b0};
               cnt_ff    <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= (state_ff == S_FALL) ? S_AMP : S_LLD;
               end
            end

            // volume times falloff
            S_AMP: begin
               prod_ff  <= mul_p;
               state_ff <= S_PLD;
            end

            // pan: clamp hard left, else divide
            S_PLD: begin
               amp_ff       <= prod_ff[24:0];
               pan_clamp_ff <= pan_num[17] || sub_ge;
               rem_ff       <= {9'b0, pan_num[16:0]};
               quo_ff       <= '0;
               sticky_ff    <= 1'b0;
               shf_ff       <= '0;
               cnt_ff       <= CNT_W'(FRAC_STEPS - 1);
               state_ff     <= (pan_num[17] || sub_ge) ? S_LLD : S_PAN;
            end

            S_LLD: begin
               shf_ff   <= {15'b0, lpan, 16'b0};
               rpan_ff  <= Q16_ONE - lpan;
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= CNT_W'(SQRT_STEPS - 1);
               state_ff <= S_SQL;
            end

            // left gain product, start right pan root
            S_GL: begin
               prod_ff  <= mul_p;
               shf_ff   <= {15'b0, rpan_ff, 16'b0};
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= CNT_W'(SQRT_STEPS - 1);
               state_ff <= S_SQR;
            end
            S_GR: begin
               prod_ff  <= mul_p;
               lgain_ff <= prod_ff[39:32];
               state_ff <= S_GRC;
            end
            S_GRC: begin
               rgain_ff <= prod_ff[39:32];
               state_ff <= S_MULL;
            end

            // sample times gain into the sums
            S_MULL: begin
               prod_ff  <= mul_p;
               state_ff <= S_MULR;
            end
            S_MULR: begin
               prod_ff     <= mul_p;
               left_sum_ff <= left_sum_ff + SUM_W'($signed(prod_ff[24:0]));
               state_ff    <= S_ACCR;
            end
            S_ACCR: begin
               right_sum_ff <= right_sum_ff + SUM_W'($signed(prod_ff[24:0]));
               chan_ff      <= 1'b0;
               state_ff     <= item_ff.last_voice ? S_FIN : S_IDLE;
            end

            // frame end: scale, divide, saturate each channel
            S_FIN: begin
               prod_ff  <= mul_p;
               state_ff <= S_FLD;
            end
            // flag quotients that saturate either way, keep the low dividend bits
            S_FLD: begin
               neg_ff    <= prod_ff[58];
               sticky_ff <= (fin_abs[46:31] != '0) ||
                            (fin_abs[30:24] >= 7'(FINAL_DIVISOR));
               d2_ff     <= {1'b0, fin_abs[30:0]};
               state_ff  <= S_FLO;
            end
            // reciprocal product, low half then high half
            S_FLO: begin
               prod_ff  <= mul_p;
               state_ff <= S_FHI;
            end
            S_FHI: begin
               shf_ff   <= mul_p[47:0];
               state_ff <= S_FDIV;
            end
            S_FDIV: begin
               quo_ff   <= fdiv_sum[45:22];
               state_ff <= S_FSAT;
            end
            S_FSAT: begin
               if (!chan_ff) begin
                  lout_ff  <= sat_val;
                  chan_ff  <= 1'b1;
                  state_ff <= S_FIN;
               end else if (rsp_slot_free) begin
                  rsp_data_ff.left_out  <= lout_ff;
                  rsp_data_ff.right_out <= sat_val;
                  left_sum_ff           <= '0;
                  right_sum_ff          <= '0;
                  state_ff              <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // a frame is raised only from the saturation step
   `PVM_ASSERT_IMPLIES(a_rsp_from_fsat, clock, reset, $rose(rsp_valid_ff), $past(frame_done))
   // emitting a frame clears both sums
   `PVM_ASSERT_NEXT(a_sums_cleared, clock, reset, frame_done, (left_sum_ff | right_sum_ff) == '0)
   // emitting a frame frees the block
   `PVM_ASSERT_NEXT(a_idle_after_frame, clock, reset, frame_done, req_ready)
   // an unsaturated quotient fits in 24 bits
   `PVM_ASSERT_IMPLIES(a_fdiv_fit, clock, reset, (state_ff == S_FDIV) && !sticky_ff, fdiv_sum[47:46] == '0)

endmodule

// ----- verif/positional_voice_mixer_tb.sv -----
// Self-checking testbench for the positional voice mixer
`timescale 1ns / 1ps

module positional_voice_mixer_tb;
   import pvm_pkg::*;

   localparam int HOLD_CYCLES    = 600;
   localparam int DRAIN_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_VOICES   = 115;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SPARSE,
      READY_PERIODIC
   } stall_mode_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_data_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx   = CSR_MAX_DISTANCE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state and configuration copy
   logic [15:0]      cfg_max_distance  = RESET_MAX_DISTANCE;
   logic [6:0]       cfg_master_volume = RESET_MASTER_VOLUME;
   logic [SUM_W-1:0] left_mix  = '0;
   logic [SUM_W-1:0] right_mix = '0;

   req_data_type voice_q[$];
   rsp_data_type frame_q[$];

   int             voices_offered = 0;
   int             voices_taken   = 0;
   int             errors         = 0;
   int             burst_left     = 0;
   int             gap_left       = 0;
   int             hold_left      = 0;
   int             cycle_count    = 0;
   int             quiet_cycles   = 0;
   bit             steady         = 1'b0;
   bit             hold_request   = 1'b0;
   stall_mode_type stall_mode     = READY_ALWAYS;

   positional_voice_mixer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // integer square root, built one result bit at a time from the top
   function automatic longint floor_root(input longint n);
      longint root;
      longint trial;
      root = 0;
      for (int b = 27; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= n)
            root = trial;
      end
      return root;
   endfunction

   // master volume, divide by 101 toward zero, floor shift by 8, saturate
   function automatic logic signed [15:0] scale_out(input logic [SUM_W-1:0] total);
      longint level;
      level = longint'(signed'(total)) * longint'(cfg_master_volume);
      level = level / FINAL_DIVISOR;
      level = level >>> 8;
      if (level > 32767)
         level = 32767;
      else if (level < -32768)
         level = -32768;
      return 16'(level);
   endfunction

   // work out the gains of one voice, add it into the sums, close the frame on last
   function automatic void mix_voice(input req_data_type v);
      longint dx;
      longint dy;
      longint reach;
      longint dist_q8;
      longint fade;
      longint lpan;
      longint amp;
      longint lgain;
      longint rgain;
      rsp_data_type frame;
      dx    = longint'(signed'(v.offset_x));
      dy    = longint'(signed'(v.offset_y));
      lgain = longint'(v.channel_volume);
      rgain = lgain;
      if (v.positional) begin
         dist_q8 = floor_root((dx * dx + dy * dy) << 16);
         reach   = longint'(cfg_max_distance) << 8;
         if (dist_q8 < reach) begin
            fade = ((reach - dist_q8) << 16) / reach;
            lpan = ((longint'(cfg_max_distance) - dx) << 16)
                   / (2 * longint'(cfg_max_distance));
            if (lpan > 65536)
               lpan = 65536;
            amp   = lgain * fade;
            lgain = (amp * floor_root(lpan << 16)) >>> 32;
            rgain = (amp * floor_root((65536 - lpan) << 16)) >>> 32;
         end else begin
            // at or beyond the falloff distance, or no distance at all
            lgain = 0;
            rgain = 0;
         end
      end
      left_mix  = left_mix + SUM_W'(longint'(signed'(v.left_sample)) * lgain);
      right_mix = right_mix + SUM_W'(longint'(signed'(v.right_sample)) * rgain);
      if (v.last_voice) begin
         frame.left_out  = scale_out(left_mix);
         frame.right_out = scale_out(right_mix);
         frame_q.push_back(frame);
         left_mix  = '0;
         right_mix = '0;
      end
   endfunction

   function automatic req_data_type voice_of(input int ls, input int rs, input int vol,
                                             input bit pos, input int dx, input int dy,
                                             input bit last);
      req_data_type v;
      v.left_sample    = 16'(ls);
      v.right_sample   = 16'(rs);
      v.channel_volume = 8'(vol);
      v.positional     = pos;
      v.offset_x       = 16'(dx);
      v.offset_y       = 16'(dy);
      v.last_voice     = last;
      return v;
   endfunction

   function automatic logic signed [15:0] random_sample();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      return 16'($urandom);
   endfunction

   // random voice, offsets mostly around the current falloff distance
   function automatic req_data_type random_voice(input bit last);
      req_data_type v;
      int span;
      v.left_sample  = random_sample();
      v.right_sample = ($urandom_range(0, 3) == 0) ? v.left_sample : random_sample();
      if ($urandom_range(0, 3) == 0)
         v.channel_volume = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      else
         v.channel_volume = 8'($urandom);
      v.positional = ($urandom_range(0, 2) != 0);
      span = int'(cfg_max_distance) + int'(cfg_max_distance) / 8 + 1;
      if (span > 32767)
         span = 32767;
      if ($urandom_range(0, 9) < 7) begin
         v.offset_x = 16'($urandom_range(0, 2 * span) - span);
         v.offset_y = 16'($urandom_range(0, span) - span / 2);
      end else begin
         v.offset_x = 16'($urandom);
         v.offset_y = 16'($urandom);
      end
      v.last_voice = last;
      return v;
   endfunction

   function automatic void offer(input req_data_type v);
      voice_q.push_back(v);
      voices_offered++;
   endfunction

   // wait for every beat and frame to pass, then let the block go quiet
   task automatic settle();
      while (voices_taken != voices_offered || frame_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] distance, input logic [6:0] volume);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= CSR_MAX_DISTANCE;
      csr_wdata <= distance;
      cfg_max_distance = distance;
      @(posedge clock);
      csr_idx   <= CSR_MASTER_VOLUME;
      csr_wdata <= {9'($urandom), volume};
      cfg_master_volume = volume;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sender: bursts of beats with random gaps, predict on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            mix_voice(req_data);
            voices_taken++;
         end
         if (!req_valid || req_ready) begin
            if (!steady && gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (voice_q.size() > 0) begin
               req_data  <= voice_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each frame beat, stall on a randomly reselected pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         cycle_count++;
         if (rsp_valid && rsp_ready) begin
            if (frame_q.size() == 0) begin
               $display("%0t: unexpected frame, got left %0d right %0d",
                        $time, rsp_data.left_out, rsp_data.right_out);
               errors++;
            end else begin
               if (rsp_data.left_out !== frame_q[0].left_out) begin
                  $display("%0t: left_out expected %0d, got %0d",
                           $time, frame_q[0].left_out, rsp_data.left_out);
                  errors++;
               end
               if (rsp_data.right_out !== frame_q[0].right_out) begin
                  $display("%0t: right_out expected %0d, got %0d",
                           $time, frame_q[0].right_out, rsp_data.right_out);
                  errors++;
               end
               void'(frame_q.pop_front());
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (cycle_count % 256 == 0)
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            case (stall_mode)
               READY_ALWAYS:   rsp_ready <= 1'b1;
               READY_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
               READY_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
               default:        rsp_ready <= (cycle_count % 7 < 3);
            endcase
         end
      end
   end

   // abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_data_type v;
      int frame_len;
      int count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // plain voices: full scale, silent channel, saturation, small negative sum
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 0, 0, 0, 1));
      offer(voice_of(1234, -1234, 0, 0, 0, 0, 1));
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 0, 0, 0, 0));
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 0, 0, 0, 1));
      offer(voice_of(-300, -1, 1, 0, 0, 0, 1));
      // positional: centre, near the edges on both axes, on the edge, far corners
      offer(voice_of(SAMPLE_MAX, SAMPLE_MAX, 255, 1, 0, 0, 1));
      offer(voice_of(20000, 20000, 200, 1, 1499, 0, 1));
      offer(voice_of(20000, 20000, 200, 1, -1499, 0, 1));
      offer(voice_of(20000, -20000, 200, 1, 0, -1499, 1));
      offer(voice_of(SAMPLE_MAX, SAMPLE_MAX, 255, 1, 1500, 0, 1));
      offer(voice_of(SAMPLE_MIN, SAMPLE_MIN, 255, 1, SAMPLE_MIN, SAMPLE_MIN, 1));
      offer(voice_of(SAMPLE_MAX, SAMPLE_MAX, 255, 1, SAMPLE_MAX, SAMPLE_MAX, 1));
      settle();

      // zero distance silences positional voices; volume beyond 100
      configure(16'd0, 7'd127);
      offer(voice_of(SAMPLE_MAX, SAMPLE_MAX, 255, 1, 0, 0, 0));
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 0, 0, 0, 1));
      settle();

      // widest distance with master volume muted
      configure(16'hFFFF, 7'd0);
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 1, SAMPLE_MIN, SAMPLE_MAX, 1));
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 0, 0, 0, 0));
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 0, 0, 0, 1));
      settle();

      // smallest distance: only the listener's own spot is audible
      configure(16'd1, 7'd100);
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 1, 0, 0, 1));
      offer(voice_of(SAMPLE_MAX, SAMPLE_MIN, 255, 1, -1, 0, 1));
      settle();

      // random frames under a spread of settings
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0:       configure(16'd1, 7'd127);
            1:       configure(16'hFFFF, 7'd0);
            2:       configure(16'd0, 7'd100);
            3:       configure(16'd1500, 7'd1);
            default: configure($urandom_range(0, 1) ? 16'($urandom_range(1, 4000))
                                                    : 16'($urandom_range(1, 65535)),
                               7'($urandom_range(0, 127)));
         endcase
         steady = (phase == 5);
         if (phase == 7) begin
            // hold the receiver off while short frames pile up behind it
            hold_request = 1'b1;
            repeat (12) begin
               v = random_voice(1'b1);
               v.positional = 1'b0;
               offer(v);
            end
         end
         count = 0;
         while (count < PHASE_VOICES) begin
            frame_len = ($urandom_range(0, 24) == 0) ? $urandom_range(65, 80)
                                                     : $urandom_range(1, 8);
            // a frame cut short by the end of the phase carries its sums onward
            for (int i = 0; i < frame_len && count < PHASE_VOICES; i++) begin
               offer(random_voice(i == frame_len - 1));
               count++;
            end
         end
         settle();
         steady = 1'b0;
      end

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
